/* rtl/msc_pkg.sv */
// ----------------------------------------------------------------------------
// msc_pkg
// Types, codes and reset values shared by the motor safety controller.
// ----------------------------------------------------------------------------
`default_nettype none

package msc_pkg;

  // LED bar length, default for the top level parameter
  localparam int unsigned LedCountDef = 8;

  // Register indexes of the configuration port
  localparam logic [1:0] CFG_ENC_TIMEOUT = 2'd0;
  localparam logic [1:0] CFG_BLINK_INT   = 2'd1;
  localparam logic [1:0] CFG_DUTY_STEP   = 2'd2;
  localparam logic [1:0] CFG_START_DUTY  = 2'd3;

  // Register reset values
  localparam logic [15:0] ENC_TIMEOUT_RST = 16'd400;
  localparam logic [15:0] BLINK_INT_RST   = 16'd250;
  localparam logic [7:0]  DUTY_STEP_RST   = 8'd32;
  localparam logic [7:0]  START_DUTY_RST  = 8'd128;

  localparam logic [7:0]  DUTY_MAX = 8'd255;
  localparam logic [15:0] CNT_MAX  = 16'hFFFF;

  // Key characters
  localparam logic [7:0] KEY_LATCH = 8'h41;  // 'A'
  localparam logic [7:0] KEY_CW    = 8'h31;  // '1'
  localparam logic [7:0] KEY_STOP  = 8'h32;  // '2'
  localparam logic [7:0] KEY_CCW   = 8'h33;  // '3'
  localparam logic [7:0] KEY_UP    = 8'h35;  // '5'
  localparam logic [7:0] KEY_DOWN  = 8'h38;  // '8'

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_KEY   = 2'd1,
    KIND_PULSE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_FAULT  = 2'd1,
    MODE_STOP   = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    DIR_STOP = 2'd0,
    DIR_CW   = 2'd1,
    DIR_CCW  = 2'd2
  } dir_e;

  typedef enum logic [2:0] {
    COL_OFF    = 3'd0,
    COL_GREEN  = 3'd1,
    COL_BLUE   = 3'd2,
    COL_ORANGE = 3'd3,
    COL_RED    = 3'd4
  } colour_e;

  typedef struct packed {
    logic [15:0] enc_timeout;
    logic [15:0] blink_int;
    logic [7:0]  duty_step;
    logic [7:0]  start_duty;
  } cfg_t;

  typedef struct packed {
    mode_e      mode;
    dir_e       dir;
    logic [7:0] duty;
    logic       blink_on;
  } status_t;

endpackage

`default_nettype wire

/* rtl/msc_state.sv */
// ----------------------------------------------------------------------------
// msc_state
// Controller state and its per-beat update: keys, watchdog, blink timer.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_state
  import msc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        step_i,
  input  wire logic [1:0]  kind_i,
  input  wire logic [7:0]  key_i,
  input  wire cfg_t        cfg_i,
  output status_t          status_o,
  output logic [15:0]      pulse_total_o
);

  mode_e       mode_q, mode_d;
  dir_e        dir_q, dir_d;
  logic [7:0]  duty_q, duty_d;
  logic [15:0] since_q, since_d;
  logic [15:0] blink_el_q, blink_el_d;
  logic        blink_on_q, blink_on_d;
  logic [15:0] pcnt_q, pcnt_d;

  always_comb begin
    logic [8:0] sum;
    mode_d     = mode_q;
    dir_d      = dir_q;
    duty_d     = duty_q;
    since_d    = since_q;
    blink_el_d = blink_el_q;
    blink_on_d = blink_on_q;
    pcnt_d     = pcnt_q;
    sum        = {1'b0, duty_q} + {1'b0, cfg_i.duty_step};

    // apply the event
    case (kind_i)
      KIND_TICK: begin
        if (since_q != CNT_MAX) since_d = since_q + 16'd1;
        if (blink_el_q != CNT_MAX) blink_el_d = blink_el_q + 16'd1;
      end
      KIND_KEY: begin
        if (key_i == KEY_LATCH) begin
          if (mode_q != MODE_STOP) begin
            mode_d = MODE_STOP;
            duty_d = '0;
            dir_d  = DIR_STOP;
          end else begin
            mode_d = MODE_NORMAL;
          end
        end else if (mode_q != MODE_STOP) begin
          case (key_i)
            KEY_CW, KEY_CCW: begin
              dir_d = (key_i == KEY_CW) ? DIR_CW : DIR_CCW;
              if (duty_q == '0) duty_d = cfg_i.start_duty;
            end
            KEY_STOP: begin
              dir_d  = DIR_STOP;
              duty_d = '0;
            end
            KEY_UP: begin
              duty_d = sum[8] ? DUTY_MAX : sum[7:0];
            end
            KEY_DOWN: begin
              duty_d = (duty_q > cfg_i.duty_step) ? duty_q - cfg_i.duty_step : '0;
              if (duty_d == '0) dir_d = DIR_STOP;
            end
            default: ;
          endcase
        end
      end
      KIND_PULSE: begin
        pcnt_d  = pcnt_q + 16'd1;
        since_d = '0;
      end
      default: ;
    endcase

    // mode logic on the updated state
    if (mode_d == MODE_STOP) begin
      if (blink_el_d >= cfg_i.blink_int) begin
        blink_el_d = '0;
        blink_on_d = !blink_on_q;
      end
    end else if (duty_d != '0 && dir_d != DIR_STOP) begin
      mode_d = (since_d > cfg_i.enc_timeout) ? MODE_FAULT : MODE_NORMAL;
    end else begin
      since_d = '0;
      mode_d  = MODE_NORMAL;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_NORMAL;
      dir_q      <= DIR_STOP;
      duty_q     <= '0;
      since_q    <= '0;
      blink_el_q <= '0;
      blink_on_q <= 1'b0;
      pcnt_q     <= '0;
    end else if (step_i) begin
      mode_q     <= mode_d;
      dir_q      <= dir_d;
      duty_q     <= duty_d;
      since_q    <= since_d;
      blink_el_q <= blink_el_d;
      blink_on_q <= blink_on_d;
      pcnt_q     <= pcnt_d;
    end
  end

  // result reflects the state after this beat
  assign status_o.mode     = mode_d;
  assign status_o.dir      = dir_d;
  assign status_o.duty     = duty_d;
  assign status_o.blink_on = blink_on_d;
  assign pulse_total_o     = pcnt_d;

  a_stop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_STOP |-> duty_q == '0 && dir_q == DIR_STOP)
    else $error("stop mode with a running command");

  a_fault_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_FAULT |-> duty_q != '0 && dir_q != DIR_STOP)
    else $error("fault mode without a running command");

  a_pulse_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && kind_i == KIND_PULSE |=> pcnt_q == $past(pcnt_q) + 16'd1)
    else $error("pulse count did not advance");

endmodule

`default_nettype wire

/* rtl/msc_led.sv */
// ----------------------------------------------------------------------------
// msc_led
// H-bridge drive, duty gating and LED bar mask and colour from the status.
// ----------------------------------------------------------------------------
`default_nettype none

module msc_led
  import msc_pkg::*;
#(
  parameter int unsigned LED_COUNT = LedCountDef
) (
  input  wire status_t status_i,
  output logic        drive_a_o,
  output logic        drive_b_o,
  output logic [7:0]  duty_out_o,
  output logic [7:0]  led_mask_o,
  output logic [2:0]  led_colour_o
);

  logic        run;
  logic [10:0] prod;
  logic [3:0]  quot;
  logic [3:0]  n_lit;

  assign run  = status_i.mode != MODE_STOP && status_i.dir != DIR_STOP &&
                status_i.duty != '0;
  assign prod = 11'(status_i.duty) * 11'(LED_COUNT - 1);
  // divide by 255: exact for products below 255 * 256
  assign quot  = 4'((16'(prod) + (16'(prod) >> 8) + 16'd1) >> 8);
  assign n_lit = quot + 4'd1;

  always_comb begin
    drive_a_o    = 1'b0;
    drive_b_o    = 1'b0;
    duty_out_o   = '0;
    led_mask_o   = '0;
    led_colour_o = COL_OFF;
    if (run) begin
      duty_out_o = status_i.duty;
      drive_a_o  = status_i.dir == DIR_CW;
      drive_b_o  = status_i.dir != DIR_CW;
      for (int i = 0; i < 8; i++) begin
        if (i < int'(LED_COUNT)) begin
          if (status_i.dir == DIR_CW) led_mask_o[i] = 4'(i) < n_lit;
          else led_mask_o[i] = (4'(i) + n_lit) >= 4'(LED_COUNT);
        end
      end
      if (status_i.mode == MODE_FAULT) led_colour_o = COL_ORANGE;
      else if (status_i.dir == DIR_CW) led_colour_o = COL_GREEN;
      else led_colour_o = COL_BLUE;
    end else if (status_i.mode == MODE_STOP && status_i.blink_on) begin
      for (int i = 0; i < 8; i++) begin
        led_mask_o[i] = i < int'(LED_COUNT);
      end
      led_colour_o = COL_RED;
    end
  end

endmodule

`default_nettype wire

/* rtl/motor_safety_controller_core.sv */
// A beat accepted into the input register has its result written to the result register when it moves on.
// Throughput: one beat per cycle while the output is not stalled; the state update is a single pass between
// the input register and the result register, so it never stalls the stream.
// s_axis_tready drops only while both the input and the result register hold.
// Reset clears the controller state and loads the register defaults
// (timeout 400, blink interval 250, duty step 32, start duty 128).
// ----------------------------------------------------------------------------
// motor_safety_controller_core
// DC motor command controller with latching stop and encoder watchdog.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_safety_controller_core
  import msc_pkg::*;
#(
  parameter int unsigned LED_COUNT = LedCountDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // key_code
  input  wire logic [1:0]  s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // drive_a, drive_b, duty_out[7:0], mode_out[1:0], dir_out[1:0],
  // led_mask[7:0], led_colour[2:0], pulse_total[15:0], zero pad
  output logic [47:0]      m_axis_tdata
);

  cfg_t        cfg_q;
  logic        in_valid_q, out_valid_q;
  logic [1:0]  kind_q;
  logic [7:0]  key_q;
  logic        advance, step;
  status_t     status;
  logic [15:0] pulse_total;
  logic        drive_a, drive_b;
  logic [7:0]  duty_out, led_mask;
  logic [2:0]  led_colour;
  logic [40:0] result_d, result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enc_timeout <= ENC_TIMEOUT_RST;
      cfg_q.blink_int   <= BLINK_INT_RST;
      cfg_q.duty_step   <= DUTY_STEP_RST;
      cfg_q.start_duty  <= START_DUTY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ENC_TIMEOUT: cfg_q.enc_timeout <= cfg_wdata_i;
        CFG_BLINK_INT:   cfg_q.blink_int   <= cfg_wdata_i;
        CFG_DUTY_STEP:   cfg_q.duty_step   <= cfg_wdata_i[7:0];
        CFG_START_DUTY:  cfg_q.start_duty  <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign step          = in_valid_q && advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) in_valid_q <= s_axis_tvalid;
      if (advance) out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      key_q  <= s_axis_tdata;
    end
    if (step) result_q <= result_d;
  end

  msc_state u_state (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .kind_i        (kind_q),
    .key_i         (key_q),
    .cfg_i         (cfg_q),
    .status_o      (status),
    .pulse_total_o (pulse_total)
  );

  msc_led #(
    .LED_COUNT (LED_COUNT)
  ) u_led (
    .status_i     (status),
    .drive_a_o    (drive_a),
    .drive_b_o    (drive_b),
    .duty_out_o   (duty_out),
    .led_mask_o   (led_mask),
    .led_colour_o (led_colour)
  );

  assign result_d = {pulse_total, led_colour, led_mask, status.dir, status.mode,
                     duty_out, drive_b, drive_a};

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, result_q};

  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> in_valid_q && out_valid_q)
    else $error("input stalled with a free stage");

  a_drive_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("both bridge inputs driven");

  a_stop_no_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[11:10] == MODE_STOP |->
      m_axis_tdata[9:0] == 10'd0)
    else $error("drive active in stop mode");

endmodule

`default_nettype wire

/* test/motor_safety_controller_core_test.sv */
// ----------------------------------------------------------------------------
// motor_safety_controller_core_test
// Stream-level test of the motor safety controller core. Key, tick and pulse
// beats go in; an in-bench copy of the controller state predicts every result
// beat, which is checked field by field. Directed runs cover the key set,
// zero and full-scale settings and duty saturation; random runs follow under
// several idle and stall mixes with fresh register settings each time.
// ----------------------------------------------------------------------------
`default_nettype none

module motor_safety_controller_core_test;
  import msc_pkg::*;

  localparam int LedCount = LedCountDef;
  localparam logic [1:0] KIND_NONE = 2'd3;
  localparam int Latency = 2;
  localparam int QuietLimit = 2000;
  localparam int ReportMax = 10;

  // result beat, lowest field in the lowest bits
  typedef struct packed {
    logic [6:0]  pad;
    logic [15:0] pulse_total;
    colour_e     colour;
    logic [7:0]  led_mask;
    dir_e        dir;
    mode_e       mode;
    logic [7:0]  duty;
    logic        drive_b;
    logic        drive_a;
  } motor_out_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = CFG_ENC_TIMEOUT;
  logic [15:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;   // key_code
  logic [1:0]  s_axis_tuser = KIND_TICK;  // kind
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // drive_a, drive_b, duty_out, mode_out, dir_out, led_mask, led_colour,
  // pulse_total, zero pad
  logic [47:0] m_axis_tdata;

  // controller copy
  cfg_t        cfg;
  mode_e       mode_q;
  dir_e        dir_q;
  logic [7:0]  duty_q;
  logic [15:0] since_pulse_q;
  logic [15:0] blink_cnt_q;
  logic        blink_on_q;
  logic [15:0] pulse_cnt_q;

  motor_out_t  motor_out_q[$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatches = 0;

  motor_safety_controller_core #(
    .LED_COUNT(LedCount)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [15:0] inc_sat16(input logic [15:0] v);
    return (v == CNT_MAX) ? v : v + 16'd1;
  endfunction

  task automatic reset_controller_copy();
    cfg.enc_timeout = ENC_TIMEOUT_RST;
    cfg.blink_int   = BLINK_INT_RST;
    cfg.duty_step   = DUTY_STEP_RST;
    cfg.start_duty  = START_DUTY_RST;
    mode_q        = MODE_NORMAL;
    dir_q         = DIR_STOP;
    duty_q        = '0;
    since_pulse_q = '0;
    blink_cnt_q   = '0;
    blink_on_q    = 1'b0;
    pulse_cnt_q   = '0;
  endtask

  task automatic press_key(input logic [7:0] key);
    int sum;
    if (key == KEY_LATCH) begin
      if (mode_q != MODE_STOP) begin
        mode_q = MODE_STOP;
        duty_q = '0;
        dir_q  = DIR_STOP;
      end else begin
        mode_q = MODE_NORMAL;
      end
    end else if (mode_q != MODE_STOP) begin
      case (key)
        KEY_CW, KEY_CCW: begin
          if (key == KEY_CW) dir_q = DIR_CW;
          else dir_q = DIR_CCW;
          if (duty_q == 8'd0) duty_q = cfg.start_duty;
        end
        KEY_STOP: begin
          dir_q  = DIR_STOP;
          duty_q = '0;
        end
        KEY_UP: begin
          sum = int'(duty_q) + int'(cfg.duty_step);
          duty_q = (sum > 255) ? DUTY_MAX : sum[7:0];
        end
        KEY_DOWN: begin
          duty_q = (duty_q > cfg.duty_step) ? duty_q - cfg.duty_step : 8'd0;
          if (duty_q == 8'd0) dir_q = DIR_STOP;
        end
        default: ;
      endcase
    end
  endtask

  // Advance the controller copy by one event and queue the result it gives.
  task automatic predict_motor_out(input logic [1:0] kind, input logic [7:0] key);
    motor_out_t r;
    int n;
    int bar;
    int all_leds;
    case (kind)
      KIND_TICK: begin
        since_pulse_q = inc_sat16(since_pulse_q);
        blink_cnt_q   = inc_sat16(blink_cnt_q);
      end
      KIND_KEY: press_key(key);
      KIND_PULSE: begin
        pulse_cnt_q   = pulse_cnt_q + 16'd1;
        since_pulse_q = '0;
      end
      default: ;
    endcase

    if (mode_q == MODE_STOP) begin
      if (blink_cnt_q >= cfg.blink_int) begin
        blink_cnt_q = '0;
        blink_on_q  = !blink_on_q;
      end
    end else if (duty_q != 8'd0 && dir_q != DIR_STOP) begin
      if (since_pulse_q > cfg.enc_timeout) mode_q = MODE_FAULT;
      else mode_q = MODE_NORMAL;
    end else begin
      since_pulse_q = '0;
      mode_q = MODE_NORMAL;
    end

    all_leds = (1 << LedCount) - 1;
    r = '0;
    r.mode = mode_q;
    r.dir = dir_q;
    r.pulse_total = pulse_cnt_q;
    r.colour = COL_OFF;
    if (mode_q != MODE_STOP && dir_q != DIR_STOP && duty_q != 8'd0) begin
      n = 1 + (int'(duty_q) * (LedCount - 1)) / 255;
      bar = ((1 << n) - 1) & all_leds;
      r.duty = duty_q;
      if (dir_q == DIR_CW) begin
        r.drive_a = 1'b1;
        r.led_mask = 8'(bar);
      end else begin
        r.drive_b = 1'b1;
        r.led_mask = 8'((bar << (LedCount - n)) & all_leds);
      end
      if (mode_q == MODE_FAULT) r.colour = COL_ORANGE;
      else if (dir_q == DIR_CW) r.colour = COL_GREEN;
      else r.colour = COL_BLUE;
    end else if (mode_q == MODE_STOP && blink_on_q) begin
      r.led_mask = 8'(all_leds);
      r.colour = COL_RED;
    end
    motor_out_q.push_back(r);
  endtask

  task automatic send_event(input logic [1:0] kind, input logic [7:0] key);
    @(negedge clk_i);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= key;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_motor_out(kind, key);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      CFG_ENC_TIMEOUT: cfg.enc_timeout = value;
      CFG_BLINK_INT:   cfg.blink_int   = value;
      CFG_DUTY_STEP:   cfg.duty_step   = value[7:0];
      CFG_START_DUTY:  cfg.start_duty  = value[7:0];
      default: ;
    endcase
  endtask

  // Hold off until every predicted beat has come back and the pipe is empty.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (motor_out_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= ReportMax)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    motor_out_t want;
    motor_out_t got;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (motor_out_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result beat %h", m_axis_tdata);
      end else begin
        want = motor_out_q.pop_front();
        check_field("drive_a", want.drive_a, got.drive_a);
        check_field("drive_b", want.drive_b, got.drive_b);
        check_field("duty_out", want.duty, got.duty);
        check_field("mode_out", want.mode, got.mode);
        check_field("dir_out", want.dir, got.dir);
        check_field("led_mask", want.led_mask, got.led_mask);
        check_field("led_colour", want.colour, got.colour);
        check_field("pulse_total", want.pulse_total, got.pulse_total);
        check_field("pad", want.pad, got.pad);
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      m_axis_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Stop the run when no beat moves on either side for too long.
  initial begin : quiet_watch
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
      else quiet++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic test_key_commands();
    send_event(KIND_KEY, KEY_UP);     // duty rises while stopped, no drive
    send_event(KIND_KEY, KEY_CW);
    repeat (8) send_event(KIND_KEY, KEY_UP);
    send_event(KIND_KEY, KEY_DOWN);
    send_event(KIND_KEY, KEY_CCW);
    send_event(KIND_TICK, 8'h00);
    send_event(KIND_PULSE, 8'hFF);
    send_event(KIND_NONE, 8'hA5);
    send_event(KIND_KEY, 8'h00);      // unknown keys
    send_event(KIND_KEY, 8'hFF);
    send_event(KIND_KEY, KEY_STOP);
    send_event(KIND_KEY, KEY_DOWN);
    send_event(KIND_KEY, KEY_CW);
    send_event(KIND_KEY, KEY_LATCH);
    send_event(KIND_KEY, KEY_UP);     // locked out
    send_event(KIND_TICK, 8'h5A);
    send_event(KIND_KEY, KEY_LATCH);
    drain_results();
  endtask

  task automatic test_zero_settings();
    write_reg(CFG_ENC_TIMEOUT, 16'd0);
    write_reg(CFG_BLINK_INT, 16'd0);
    write_reg(CFG_DUTY_STEP, 16'd0);
    write_reg(CFG_START_DUTY, 16'd0);
    send_event(KIND_KEY, KEY_CW);     // direction only
    send_event(KIND_KEY, KEY_UP);
    send_event(KIND_KEY, KEY_DOWN);
    send_event(KIND_KEY, KEY_LATCH);
    send_event(KIND_TICK, 8'h00);
    send_event(KIND_NONE, 8'h00);
    send_event(KIND_PULSE, 8'h00);
    send_event(KIND_KEY, KEY_LATCH);
    drain_results();
    write_reg(CFG_DUTY_STEP, {8'hFF, DUTY_MAX});
    write_reg(CFG_START_DUTY, {8'hFF, DUTY_MAX});
    send_event(KIND_KEY, KEY_CCW);
    send_event(KIND_TICK, 8'h00);     // zero timeout: fault at once
    send_event(KIND_PULSE, 8'h00);
    send_event(KIND_KEY, KEY_UP);
    send_event(KIND_KEY, KEY_DOWN);
    drain_results();
  endtask

  // Full-scale timers stay quiet; small steps walk the duty into saturation.
  task automatic test_wide_settings();
    write_reg(CFG_ENC_TIMEOUT, CNT_MAX);
    write_reg(CFG_BLINK_INT, CNT_MAX);
    write_reg(CFG_DUTY_STEP, 16'd1);
    write_reg(CFG_START_DUTY, 16'd200);
    send_event(KIND_KEY, KEY_CW);
    repeat (6) send_event(KIND_TICK, 8'h00);
    repeat (60) send_event(KIND_KEY, KEY_UP);
    send_event(KIND_KEY, KEY_LATCH);
    repeat (4) send_event(KIND_PULSE, 8'h00);
    send_event(KIND_KEY, KEY_LATCH);
    send_event(KIND_KEY, KEY_CCW);
    send_event(KIND_TICK, 8'h00);
    drain_results();
  endtask

  function automatic logic [15:0] pick_count_reg();
    case ($urandom_range(9, 0))
      0: return 16'd0;
      1: return 16'd1;
      2: return CNT_MAX;
      3: return 16'($urandom());
      default: return 16'($urandom_range(12, 2));
    endcase
  endfunction

  function automatic logic [15:0] pick_duty_reg();
    logic [7:0] v;
    case ($urandom_range(7, 0))
      0: v = 8'd0;
      1: v = DUTY_MAX;
      2: v = 8'd1;
      default: v = 8'($urandom());
    endcase
    return {8'($urandom()), v};
  endfunction

  function automatic logic [7:0] pick_key();
    case ($urandom_range(13, 0))
      0: return KEY_LATCH;
      1, 2: return KEY_CW;
      3, 4: return KEY_CCW;
      5: return KEY_STOP;
      6, 7, 8: return KEY_UP;
      9, 10: return KEY_DOWN;
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int items);
    int pulse_pct;
    int r;
    pulse_pct = 0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    write_reg(CFG_ENC_TIMEOUT, pick_count_reg());
    write_reg(CFG_BLINK_INT, pick_count_reg());
    write_reg(CFG_DUTY_STEP, pick_duty_reg());
    write_reg(CFG_START_DUTY, pick_duty_reg());
    for (int i = 0; i < items; i++) begin
      // vary pulse density per burst so the watchdog both trips and recovers
      if (i % 20 == 0) begin
        case ($urandom_range(2, 0))
          0: pulse_pct = 0;
          1: pulse_pct = 4;
          default: pulse_pct = 15;
        endcase
      end
      r = $urandom_range(99, 0);
      if (r < 4) send_event(KIND_NONE, 8'($urandom()));
      else if (r < 4 + pulse_pct) send_event(KIND_PULSE, 8'($urandom()));
      else if (r < 70) send_event(KIND_TICK, 8'($urandom()));
      else send_event(KIND_KEY, pick_key());
    end
    drain_results();
  endtask

  initial begin
    reset_controller_copy();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_key_commands();
    test_zero_settings();
    test_wide_settings();
    test_random_traffic(0, 0, 120);
    test_random_traffic(58, 0, 120);
    test_random_traffic(0, 58, 120);
    test_random_traffic(33, 33, 120);

    if (mismatches == 0 && motor_out_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
rtl/msc_pkg.sv
rtl/msc_state.sv
rtl/msc_led.sv
rtl/motor_safety_controller_core.sv
test/motor_safety_controller_core_test.sv
